@@ rtl/core/u8bmp_pkg.sv @@
package u8bmp_pkg;

   localparam int unsigned RSP_FIFO_DEPTH = 8;

   localparam logic [7:0] LEAD3_MIN  = 8'hE0;
   localparam logic [7:0] LEAD2_MIN  = 8'hC0;
   localparam logic [5:0] CONT_MASK  = 6'h3F;
   localparam logic [3:0] LEAD3_MASK = 4'hF;
   localparam logic [4:0] LEAD2_MASK = 5'h1F;

   typedef enum logic [1:0] {
      ST_CHAR  = 2'd0,
      ST_DONE  = 2'd1,
      ST_BAD   = 2'd2,
      ST_SMALL = 2'd3
   } status_type;

   // per-string decode state
   typedef struct packed {
      logic [1:0]  pending;
      logic [15:0] partial;
      logic [15:0] emitted;
      logic        dropping;
   } dec_state_type;

   typedef struct packed {
      logic [15:0] code_point;
      status_type  status;
      logic [15:0] char_count;
      logic        last;
   } rsp_item_type;

endpackage

@@ rtl/core/u8bmp_step.sv @@
module u8bmp_step
   import u8bmp_pkg::*;
(
   input  logic [7:0]    data_byte,
   input  logic          end_of_string,
   input  logic [15:0]   capacity,
   input  dec_state_type state_cur,
   output dec_state_type state_nxt,
   output logic [1:0]    n_push,
   output rsp_item_type  res0,
   output rsp_item_type  res1
);

   always_comb begin
      dec_state_type st;
      logic          have_char;
      logic [15:0]   code;
      logic [15:0]   gathered;
      rsp_item_type  fin;

      st        = state_cur;
      have_char = 1'b0;
      code      = '0;
      gathered  = {state_cur.partial[9:0], data_byte[5:0] & CONT_MASK};
      n_push    = 2'd0;
      res0      = '{code_point: '0, status: ST_CHAR, char_count: '0, last: 1'b0};
      res1      = res0;
      fin       = res0;

      if (state_cur.dropping) begin
         if (end_of_string) begin
            st = '0;
         end
      end else if (state_cur.pending == 2'd0 && state_cur.emitted == 16'd0 &&
                   capacity == 16'd0) begin
         res0   = '{code_point: '0, status: ST_SMALL, char_count: state_cur.emitted,
                    last: 1'b1};
         n_push = 2'd1;
         if (end_of_string) begin
            st = '0;
         end else begin
            st.pending  = 2'd0;
            st.partial  = '0;
            st.dropping = 1'b1;
         end
      end else begin
         if (state_cur.pending != 2'd0) begin
            st.pending = state_cur.pending - 2'd1;
            if (st.pending == 2'd0) begin
               have_char  = 1'b1;
               code       = gathered;
               st.partial = '0;
            end else begin
               st.partial = gathered;
            end
         end else if (data_byte >= LEAD3_MIN) begin
            st.partial = {12'd0, data_byte[3:0] & LEAD3_MASK};
            st.pending = 2'd2;
         end else if (data_byte >= LEAD2_MIN) begin
            st.partial = {11'd0, data_byte[4:0] & LEAD2_MASK};
            st.pending = 2'd1;
         end else begin
            have_char = 1'b1;
            code      = {8'd0, data_byte};
         end

         // count + 1 > capacity without widening
         if (have_char && state_cur.emitted >= capacity) begin
            res0   = '{code_point: '0, status: ST_SMALL, char_count: state_cur.emitted,
                       last: 1'b1};
            n_push = 2'd1;
            if (end_of_string) begin
               st = '0;
            end else begin
               st.pending  = 2'd0;
               st.partial  = '0;
               st.emitted  = state_cur.emitted;
               st.dropping = 1'b1;
            end
         end else begin
            if (have_char) begin
               st.emitted = state_cur.emitted + 16'd1;
               res0 = '{code_point: code, status: ST_CHAR, char_count: st.emitted,
                        last: 1'b0};
            end
            if (end_of_string) begin
               fin = '{code_point: '0,
                       status: (st.pending != 2'd0) ? ST_BAD : ST_DONE,
                       char_count: st.emitted, last: 1'b1};
               st  = '0;
            end
            if (have_char) begin
               res1   = fin;
               n_push = end_of_string ? 2'd2 : 2'd1;
            end else begin
               res0   = fin;
               n_push = end_of_string ? 2'd1 : 2'd0;
            end
         end
      end

      state_nxt = st;
   end

endmodule

@@ rtl/core/utf8_bmp_decoder.sv @@
// An accepted byte is held in the stage register, decoded, and its results are
// written into the result FIFO. Throughput: one byte per cycle while the FIFO has
// room (req_tready); results leave at most one per cycle, so a byte that yields two
// results (character plus end report) relies on the result FIFO of FIFO_DEPTH entries.
// Reset (synchronous): decode state and FIFO cleared, capacity set to 65535.
module utf8_bmp_decoder
   import u8bmp_pkg::*;
#(
   parameter int unsigned FIFO_DEPTH = RSP_FIFO_DEPTH  // power of two, >= 4
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte
   input  logic        req_tlast,   // end_of_string

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // code_point[15:0], char_count[31:16]
   output logic [1:0]  rsp_tuser,   // status
   output logic        rsp_tlast,   // last

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data     // capacity
);

   localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
   localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(FIFO_DEPTH);

   logic [15:0]    capacity_ff;
   logic           stg_v_ff;
   logic [7:0]     stg_byte_ff;
   logic           stg_eos_ff;
   dec_state_type  state_ff, state_in;

   logic [1:0]     n_push, n_act;
   rsp_item_type   res0, res1;

   rsp_item_type   fifo_mem [FIFO_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] fifo_cnt_ff, free_cnt;
   logic           pop;
   rsp_item_type   head;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= 16'hFFFF;
      end else if (csr_valid && csr_ready) begin
         capacity_ff <= csr_data;
      end
   end

   // stage register holds one byte; it always drains into the FIFO next cycle
   assign free_cnt   = DEPTH_C - fifo_cnt_ff;
   assign req_tready = stg_v_ff ? (free_cnt >= CNT_W'(4)) : (free_cnt >= CNT_W'(2));

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_v_ff <= 1'b0;
      end else begin
         stg_v_ff <= req_tvalid && req_tready;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         stg_byte_ff <= req_tdata;
         stg_eos_ff  <= req_tlast;
      end
   end

   u8bmp_step u_step (
      .data_byte     (stg_byte_ff),
      .end_of_string (stg_eos_ff),
      .capacity      (capacity_ff),
      .state_cur     (state_ff),
      .state_nxt     (state_in),
      .n_push        (n_push),
      .res0          (res0),
      .res1          (res1)
   );

   assign n_act = stg_v_ff ? n_push : 2'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (stg_v_ff) begin
         state_ff <= state_in;
      end
   end

   // result FIFO
   assign pop        = rsp_tvalid && rsp_tready;
   assign rsp_tvalid = fifo_cnt_ff != '0;
   assign head       = fifo_mem[rd_ptr_ff];
   assign rsp_tdata  = {head.char_count, head.code_point};
   assign rsp_tuser  = head.status;
   assign rsp_tlast  = head.last;

   always_ff @(posedge clock) begin
      if (n_act != 2'd0) begin
         fifo_mem[wr_ptr_ff] <= res0;
      end
      if (n_act == 2'd2) begin
         fifo_mem[wr_ptr_ff + PTR_W'(1)] <= res1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         fifo_cnt_ff <= '0;
      end else begin
         wr_ptr_ff   <= wr_ptr_ff + PTR_W'(n_act);
         rd_ptr_ff   <= rd_ptr_ff + PTR_W'(pop);
         fifo_cnt_ff <= fifo_cnt_ff + CNT_W'(n_act) - CNT_W'(pop);
      end
   end

`ifndef SYNTH
   a_fifo_bound: assert property (@(posedge clock) disable iff (reset)
      fifo_cnt_ff <= DEPTH_C)
      else $error("result FIFO count beyond depth");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      stg_v_ff |-> (free_cnt >= CNT_W'(n_push)))
      else $error("result FIFO overflow on push");

   a_drop_clean: assert property (@(posedge clock) disable iff (reset)
      state_ff.dropping |-> (state_ff.pending == 2'd0 && state_ff.partial == 16'd0))
      else $error("dropping with a sequence still open");

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (stg_v_ff && stg_eos_ff) |=> (state_ff == '0))
      else $error("string state not cleared after end of string");
`endif

endmodule
